[src/skn_pkg.sv]
// Shared constants, payload types and character helpers for the subject key normalizer.
// Used by the interfaces, the scanner, the writer and the top level. No dependencies.
package skn_pkg;

    localparam int KEY_MAX         = 80;
    localparam int PREFIX_WORD_MAX = 8;
    localparam int TAG_MAX         = 16;
    localparam int WAS_MIN_POS     = 8;

    // A closed tag is the longest run that is ever buffered: bracket, body and bracket.
    localparam int BUF_DEPTH = TAG_MAX + 2;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int POS_W     = 7;

    localparam logic [POS_W-1:0] KEY_LAST = POS_W'(KEY_MAX - 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_W  = 8'h77;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_S  = 8'h73;

    typedef struct packed {
        logic [7:0] in_char;
        logic       has_char;
        logic       last_char;
    } t_subj;

    typedef struct packed {
        logic [7:0]       out_char;
        logic [POS_W-1:0] out_pos;
        logic             is_end;
        logic [POS_W-1:0] final_len;
    } t_key;

    // One byte handed from the scanner to the writer, or the end-of-subject marker.
    typedef struct packed {
        logic       is_end;
        logic [7:0] ch;
    } t_tok;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

[src/skn_in_if.sv]
// Valid/ready channel that carries one subject byte per transaction.
// Depends on skn_pkg for the payload type.
interface skn_in_if;
    logic              valid;
    logic              ready;
    skn_pkg::t_subj    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/skn_out_if.sv]
// Valid/ready channel that carries one key write or the closing length per transaction.
// Depends on skn_pkg for the payload type.
interface skn_out_if;
    logic              valid;
    logic              ready;
    skn_pkg::t_key     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/subject_key_normalizer.sv]
// Subject key normalizer: a mail subject goes in one byte per transaction and the writes of
// its thread key come out, followed by one closing transaction that carries the final length.
// While the leading reply prefixes and bracket tags are scanned, and once the key is being
// written, one byte is taken per cycle as long as the writer and the output accept it; a key
// character that follows a collapsed whitespace run is held while a space and the character
// leave as two transactions. When the prefix scan breaks off or the subject ends, the buffered
// word or tag (at most 18 bytes) is replayed from a single-port synchronous RAM, one entry per
// cycle while the writer accepts them, after a read start state; input pauses during the replay,
// the break byte and the closing transaction. The key is lower-case alphanumeric with single spaces and
// ends at 79 characters. Depends on skn_pkg, skn_in_if, skn_out_if, skn_scanner, skn_writer.
module subject_key_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skn_in_if.sink      i_subj,
    skn_out_if.source   o_key
);

    logic               tok_valid;
    skn_pkg::t_tok      tok;
    logic               tok_ready;

    skn_scanner u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_subj      (i_subj),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_ready (tok_ready)
    );

    skn_writer u_writer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_ready (tok_ready),
        .o_key       (o_key)
    );

endmodule

[src/skn_scanner.sv]
// Prefix scanner: skips whitespace, reply prefixes and bracket tags, buffers the current
// word or tag in a small synchronous RAM and replays it to the writer. Uses skn_pkg, skn_in_if.
module skn_scanner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    skn_in_if.sink              i_subj,
    output logic                o_tok_valid,
    output skn_pkg::t_tok       o_tok,
    input  logic                i_tok_ready
);

    localparam logic [2:0] SC_SCAN    = 3'd0;
    localparam logic [2:0] SC_RDSTART = 3'd1;
    localparam logic [2:0] SC_RDWAIT  = 3'd2;
    localparam logic [2:0] SC_BREAK   = 3'd3;
    localparam logic [2:0] SC_END     = 3'd4;

    localparam logic [1:0] PH_WORD = 2'd0;
    localparam logic [1:0] PH_SKIP = 2'd1;
    localparam logic [1:0] PH_TAG  = 2'd2;

    logic [2:0]                   r_state, n_state;
    logic [1:0]                   r_phase, n_phase;
    logic [skn_pkg::CNT_W-1:0]    r_count, n_count;
    logic                         r_pass, n_pass;
    logic [skn_pkg::BUF_AW-1:0]   r_rd_idx, n_rd_idx;
    logic                         r_brk_pend, n_brk_pend;
    logic [7:0]                   r_brk_char, n_brk_char;
    logic                         r_end_pend, n_end_pend;
    logic                         r_tok_valid, n_tok_valid;
    skn_pkg::t_tok                r_tok, n_tok;

    logic [7:0]                   r_buf [skn_pkg::BUF_DEPTH];
    logic [7:0]                   r_rdata;

    logic                         tok_free;
    logic                         acc;
    logic [7:0]                   c;
    logic                         skip;
    logic [skn_pkg::CNT_W-1:0]    k;
    logic [1:0]                   ph;
    logic [1:0]                   scan_phase;
    logic                         idle_ws;
    logic                         brk;
    logic                         store;
    logic                         wr_en;
    logic                         rd_en;
    logic [skn_pkg::BUF_AW-1:0]   rd_addr;
    logic [2:0]                   after_replay;
    logic [skn_pkg::CNT_W-1:0]    next_idx;

    assign tok_free      = !r_tok_valid || i_tok_ready;
    assign i_subj.ready  = (r_state == SC_SCAN) && tok_free;
    assign acc           = i_subj.valid && i_subj.ready;
    assign c             = i_subj.data.in_char;
    assign o_tok_valid   = r_tok_valid;
    assign o_tok         = r_tok;

    assign skip    = (r_phase == PH_SKIP);
    assign k       = skip ? '0 : r_count;
    assign ph      = skip ? PH_WORD : r_phase;
    assign idle_ws = skip && skn_pkg::is_ws(c);

    always_comb begin
        scan_phase = ph;
        brk        = 1'b0;
        if (ph == PH_WORD) begin
            if (c == skn_pkg::CH_LBRACK && k == '0) begin
                scan_phase = PH_TAG;
            end
            if (c == skn_pkg::CH_COLON) begin
                scan_phase = PH_SKIP;
            end else if (c == skn_pkg::CH_SPACE ||
                         k > skn_pkg::CNT_W'(skn_pkg::PREFIX_WORD_MAX)) begin
                brk = 1'b1;
            end
        end else begin
            if (c == skn_pkg::CH_RBRACK) begin
                scan_phase = PH_SKIP;
            end else if (k > skn_pkg::CNT_W'(skn_pkg::TAG_MAX)) begin
                brk = 1'b1;
            end
        end
    end

    assign store = !idle_ws && !brk && (k < skn_pkg::CNT_W'(skn_pkg::BUF_DEPTH));
    assign wr_en = acc && i_subj.data.has_char && !r_pass && store;

    assign after_replay = r_brk_pend ? SC_BREAK : (r_end_pend ? SC_END : SC_SCAN);
    assign next_idx     = skn_pkg::CNT_W'(r_rd_idx) + skn_pkg::CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_pass      = r_pass;
        n_rd_idx    = r_rd_idx;
        n_brk_pend  = r_brk_pend;
        n_brk_char  = r_brk_char;
        n_end_pend  = r_end_pend;
        n_tok_valid = r_tok_valid && !i_tok_ready;
        n_tok       = r_tok;
        rd_en       = 1'b0;
        rd_addr     = r_rd_idx;
        case (r_state)
            SC_SCAN: begin
                if (acc) begin
                    if (!i_subj.data.has_char) begin
                        n_end_pend = 1'b1;
                        n_state    = r_pass ? SC_END : SC_RDSTART;
                        n_pass     = 1'b1;
                    end else if (r_pass) begin
                        n_tok_valid = 1'b1;
                        n_tok       = '{is_end: 1'b0, ch: c};
                        if (i_subj.data.last_char) begin
                            n_end_pend = 1'b1;
                            n_state    = SC_END;
                        end
                    end else if (!idle_ws) begin
                        n_phase = scan_phase;
                        n_count = store ? k + skn_pkg::CNT_W'(1) : k;
                        if (brk) begin
                            n_brk_pend = 1'b1;
                            n_brk_char = c;
                            n_end_pend = i_subj.data.last_char;
                            n_pass     = 1'b1;
                            n_state    = SC_RDSTART;
                        end else if (i_subj.data.last_char) begin
                            n_end_pend = 1'b1;
                            n_pass     = 1'b1;
                            n_state    = SC_RDSTART;
                        end
                    end else if (i_subj.data.last_char) begin
                        n_end_pend = 1'b1;
                        n_pass     = 1'b1;
                        n_state    = SC_RDSTART;
                    end
                end
            end
            SC_RDSTART: begin
                if (r_count == '0) begin
                    n_state = after_replay;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = '0;
                    n_rd_idx = '0;
                    n_state  = SC_RDWAIT;
                end
            end
            SC_RDWAIT: begin
                if (tok_free) begin
                    n_tok_valid = 1'b1;
                    n_tok       = '{is_end: 1'b0, ch: r_rdata};
                    if (next_idx < r_count) begin
                        rd_en    = 1'b1;
                        rd_addr  = next_idx[skn_pkg::BUF_AW-1:0];
                        n_rd_idx = next_idx[skn_pkg::BUF_AW-1:0];
                    end else begin
                        n_state = after_replay;
                    end
                end
            end
            SC_BREAK: begin
                if (tok_free) begin
                    n_tok_valid = 1'b1;
                    n_tok       = '{is_end: 1'b0, ch: r_brk_char};
                    n_brk_pend  = 1'b0;
                    n_state     = r_end_pend ? SC_END : SC_SCAN;
                end
            end
            SC_END: begin
                if (tok_free) begin
                    n_tok_valid = 1'b1;
                    n_tok       = '{is_end: 1'b1, ch: skn_pkg::CH_NUL};
                    n_phase     = PH_SKIP;
                    n_count     = '0;
                    n_pass      = 1'b0;
                    n_brk_pend  = 1'b0;
                    n_end_pend  = 1'b0;
                    n_state     = SC_SCAN;
                end
            end
            default: begin
                n_state = SC_SCAN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SC_SCAN;
            r_phase     <= PH_SKIP;
            r_count     <= '0;
            r_pass      <= 1'b0;
            r_rd_idx    <= '0;
            r_brk_pend  <= 1'b0;
            r_end_pend  <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_pass      <= n_pass;
            r_rd_idx    <= n_rd_idx;
            r_brk_pend  <= n_brk_pend;
            r_end_pend  <= n_end_pend;
            r_tok_valid <= n_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_brk_char <= n_brk_char;
        r_tok      <= n_tok;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[k[skn_pkg::BUF_AW-1:0]] <= c;
        end
        if (rd_en) begin
            r_rdata <= r_buf[rd_addr];
        end
    end

endmodule

[src/skn_writer.sv]
// Key writer: lower-cases alphanumerics, collapses whitespace runs, handles the full key
// and the rewind after a "was" colon, and holds the output register. Uses skn_pkg, skn_out_if.
module skn_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_valid,
    input  skn_pkg::t_tok       i_tok,
    output logic                o_tok_ready,
    skn_out_if.source           o_key
);

    localparam logic [1:0] MD_WRITE = 2'd1;
    localparam logic [1:0] MD_STOP  = 2'd2;
    localparam logic [1:0] MD_FULL  = 2'd3;

    logic [1:0]                 r_mode, n_mode;
    logic [skn_pkg::POS_W-1:0]  r_wpos, n_wpos;
    logic                       r_pend, n_pend;
    logic [23:0]                r_recent, n_recent;
    logic [skn_pkg::POS_W-1:0]  r_last_sp, n_last_sp;
    logic                       r_sp_seen, n_sp_seen;
    logic                       r_out_valid, n_out_valid;
    skn_pkg::t_key              r_out, n_out;

    logic                       slot_free;
    logic [7:0]                 c;
    logic                       was_hit;
    logic [skn_pkg::POS_W-1:0]  rewound;
    logic [skn_pkg::POS_W-1:0]  wpos_inc;
    logic [23:0]                recent_shift;

    assign slot_free    = !r_out_valid || o_key.ready;
    assign c            = i_tok.ch;
    assign was_hit      = (skn_pkg::to_lower(r_recent[23:16]) == skn_pkg::CH_LOW_W) &&
                          (skn_pkg::to_lower(r_recent[15:8])  == skn_pkg::CH_LOW_A) &&
                          (skn_pkg::to_lower(r_recent[7:0])   == skn_pkg::CH_LOW_S);
    assign rewound      = (r_sp_seen && r_last_sp != '0) ? r_last_sp : '0;
    assign wpos_inc     = r_wpos + skn_pkg::POS_W'(1);
    assign recent_shift = {r_recent[15:0], c};

    assign o_key.valid  = r_out_valid;
    assign o_key.data   = r_out;

    always_comb begin
        n_mode      = r_mode;
        n_wpos      = r_wpos;
        n_pend      = r_pend;
        n_recent    = r_recent;
        n_last_sp   = r_last_sp;
        n_sp_seen   = r_sp_seen;
        n_out_valid = r_out_valid && !o_key.ready;
        n_out       = r_out;
        o_tok_ready = 1'b0;
        if (i_tok_valid) begin
            if (i_tok.is_end) begin
                if (slot_free) begin
                    o_tok_ready = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{out_char: skn_pkg::CH_NUL, out_pos: '0,
                                    is_end: 1'b1, final_len: r_wpos};
                    n_mode      = MD_WRITE;
                    n_wpos      = '0;
                    n_pend      = 1'b0;
                    n_recent    = '0;
                    n_sp_seen   = 1'b0;
                end
            end else begin
                case (r_mode)
                    MD_FULL: begin
                        o_tok_ready = 1'b1;
                        if (c == skn_pkg::CH_COLON) begin
                            n_wpos = rewound;
                        end
                        n_mode = MD_STOP;
                    end
                    MD_WRITE: begin
                        if (skn_pkg::is_ws(c)) begin
                            o_tok_ready = 1'b1;
                            n_pend      = 1'b1;
                            n_recent    = recent_shift;
                        end else if (c == skn_pkg::CH_COLON && was_hit &&
                                     r_wpos > skn_pkg::POS_W'(skn_pkg::WAS_MIN_POS)) begin
                            o_tok_ready = 1'b1;
                            n_wpos      = rewound;
                            n_mode      = MD_STOP;
                        end else if (skn_pkg::is_alnum(c)) begin
                            if (slot_free) begin
                                n_out_valid = 1'b1;
                                if (r_pend) begin
                                    // Unless the key is full, the byte waits to be written.
                                    n_out     = '{out_char: skn_pkg::CH_SPACE, out_pos: r_wpos,
                                                  is_end: 1'b0, final_len: '0};
                                    n_last_sp = r_wpos;
                                    n_sp_seen = 1'b1;
                                    n_wpos    = wpos_inc;
                                    n_pend    = 1'b0;
                                    if (wpos_inc >= skn_pkg::KEY_LAST) begin
                                        n_mode      = MD_STOP;
                                        o_tok_ready = 1'b1;
                                    end
                                end else begin
                                    n_out       = '{out_char: skn_pkg::to_lower(c),
                                                    out_pos: r_wpos,
                                                    is_end: 1'b0, final_len: '0};
                                    n_wpos      = wpos_inc;
                                    n_recent    = recent_shift;
                                    o_tok_ready = 1'b1;
                                    if (wpos_inc >= skn_pkg::KEY_LAST) begin
                                        n_mode = MD_FULL;
                                    end
                                end
                            end
                        end else begin
                            o_tok_ready = 1'b1;
                            n_recent    = recent_shift;
                        end
                    end
                    default: begin
                        o_tok_ready = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MD_WRITE;
            r_wpos      <= '0;
            r_pend      <= 1'b0;
            r_recent    <= '0;
            r_sp_seen   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_wpos      <= n_wpos;
            r_pend      <= n_pend;
            r_recent    <= n_recent;
            r_sp_seen   <= n_sp_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_sp <= n_last_sp;
        r_out     <= n_out;
    end

endmodule
